>>> rtl/av_timestamp_mix_reorder_queue_core_macros.svh
// Assertion helpers shared by the reorder queue RTL.
// Each macro expands to one labeled concurrent assertion on the rising clock,
// disabled while the active-low reset is asserted.
`ifndef AV_TIMESTAMP_MIX_REORDER_QUEUE_CORE_MACROS_SVH
`define AV_TIMESTAMP_MIX_REORDER_QUEUE_CORE_MACROS_SVH

// Same-cycle implication.
`define ATMRQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ATMRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/atmrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atmrq_pkg
// Shared sizes, codes and helpers of the timestamp reorder queue.
// ----------------------------------------------------------------------------
package atmrq_pkg;

    localparam int DEPTH    = 16;
    localparam int TAG_BITS = 16;
    localparam int TS_W     = 32;
    localparam int THR_W    = 5;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = TS_W + TAG_BITS + 1;

    localparam logic [IDX_W:0] DEPTH_IW = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CW = CNT_W'(DEPTH);

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_MEDIA = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_ENABLE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PURE_THRESHOLD = 1'b1;

    localparam logic [THR_W-1:0] THR_RESET = 5'd10;

    typedef struct packed {
        logic [TS_W-1:0]     ts;
        logic [TAG_BITS-1:0] tag;
        logic                vid;
    } t_entry;

    // Ring position: head plus offset, wrapped at the depth.
    function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] head,
                                                  input logic [IDX_W-1:0] ofs);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, ofs};
        if (sum >= DEPTH_IW) begin
            sum = sum - DEPTH_IW;
        end
        return sum[IDX_W-1:0];
    endfunction

    // Release when both kinds are queued or one kind alone reaches the
    // threshold, clamped to 1..DEPTH.
    function automatic logic release_ok(input logic [CNT_W-1:0] vcnt,
                                        input logic [CNT_W-1:0] acnt,
                                        input logic [THR_W-1:0] thr_raw);
        logic [CNT_W-1:0] thr;
        if (thr_raw == '0) begin
            thr = CNT_W'(1);
        end else if (32'(thr_raw) > DEPTH) begin
            thr = DEPTH_CW;
        end else begin
            thr = CNT_W'(thr_raw);
        end
        return ((vcnt >= thr) && (acnt == '0)) ||
               ((acnt >= thr) && (vcnt == '0)) ||
               ((vcnt != '0) && (acnt != '0));
    endfunction

endpackage
`default_nettype wire

>>> rtl/atmrq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atmrq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module atmrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/av_timestamp_mix_reorder_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// av_timestamp_mix_reorder_queue_core
// Reorders audio/video message tags by timestamp through a RAM-backed ring in mix mode; passes them through otherwise.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries mode, kind, timestamp,
//    tag and header status. Output channel (o_out_valid / i_out_ready)
//    carries released tags with their timestamp, kind and the sticky
//    monotonic flag.
//  - Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data
//    while the block is idle; the user is bound to this, the block itself
//    does not enforce it.
//  - One message is processed at a time. A queued insert walks the ring
//    from the tail down, one entry per cycle through the RAM read/write
//    ports, moving each later entry up one slot; into an empty queue the
//    entry is written directly. A release of the head entry then runs
//    head read, take and output load, and the output load waits for a
//    stalled receiver. A new message is accepted only when the last one
//    is through, in mix and in pass-through mode alike.
//  - Reset empties the queue, clears publishing and sets the flag. The RAM
//    holds no reset contents and needs no clearing pass.
//  - A stalled receiver holds the output register; the next message is
//    still accepted and waits for the register only when it has a result.
// ----------------------------------------------------------------------------
module av_timestamp_mix_reorder_queue_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [atmrq_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [atmrq_pkg::THR_W-1:0]            i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [atmrq_pkg::MODE_W-1:0]           i_mode,
    input  wire logic                                   i_is_video,
    input  wire logic [atmrq_pkg::TS_W-1:0]             i_timestamp,
    input  wire logic [atmrq_pkg::TAG_BITS-1:0]         i_message_tag,
    input  wire logic                                   i_header_ok,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic      [atmrq_pkg::TAG_BITS-1:0]         o_out_tag,
    output logic      [atmrq_pkg::TS_W-1:0]             o_out_timestamp,
    output logic                                        o_out_is_video,
    output logic                                        o_monotonic
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_PLACE,
        ST_HEAD,
        ST_TAKE,
        ST_EMIT
    } t_state;

    t_state r_state;

    logic                              r_mix;
    logic [atmrq_pkg::THR_W-1:0]       r_thr;
    logic                              r_pub;
    logic                              r_mono;
    logic [atmrq_pkg::TS_W-1:0]        r_last;
    logic [atmrq_pkg::CNT_W-1:0]       r_occ;
    logic [atmrq_pkg::CNT_W-1:0]       r_vcnt;
    logic [atmrq_pkg::CNT_W-1:0]       r_acnt;
    logic [atmrq_pkg::IDX_W-1:0]       r_head;
    logic [atmrq_pkg::IDX_W-1:0]       r_pos;
    atmrq_pkg::t_entry                 r_new;
    atmrq_pkg::t_entry                 r_pend;
    logic                              r_out_valid;
    logic [atmrq_pkg::TAG_BITS-1:0]    r_out_tag;
    logic [atmrq_pkg::TS_W-1:0]        r_out_ts;
    logic                              r_out_vid;
    logic                              r_out_mono;

    // RAM ports
    logic                              mem_we;
    logic [atmrq_pkg::IDX_W-1:0]       mem_waddr;
    logic [atmrq_pkg::ENT_W-1:0]       mem_wdata;
    logic                              mem_re;
    logic [atmrq_pkg::IDX_W-1:0]       mem_raddr;
    logic [atmrq_pkg::ENT_W-1:0]       mem_rdata;

    atmrq_pkg::t_entry                 rd_ent;
    atmrq_pkg::t_entry                 in_ent;
    atmrq_pkg::t_entry                 cur_new;
    logic                              in_xfer;
    logic                              media_ok;
    logic                              go_ins;
    logic                              ins_done;
    logic [atmrq_pkg::IDX_W-1:0]       ins_pos;
    logic [atmrq_pkg::CNT_W-1:0]       n_vcnt;
    logic [atmrq_pkg::CNT_W-1:0]       n_acnt;
    logic                              rel;
    logic                              walk_shift;

    assign o_in_ready      = (r_state == ST_IDLE);
    assign in_xfer         = i_in_valid && o_in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_tag       = r_out_tag;
    assign o_out_timestamp = r_out_ts;
    assign o_out_is_video  = r_out_vid;
    assign o_monotonic     = r_out_mono;

    assign rd_ent = mem_rdata;
    assign in_ent = '{ts: i_timestamp, tag: i_message_tag, vid: i_is_video};

    // Media message that survives the header check while publishing
    assign media_ok = in_xfer && (i_mode == atmrq_pkg::MODE_MEDIA) && r_pub &&
                      !(i_is_video && !i_header_ok);
    assign go_ins   = media_ok && r_mix && (r_occ < atmrq_pkg::DEPTH_CW);

    assign walk_shift = (r_state == ST_WALK) && (rd_ent.ts > r_new.ts);

    always_comb begin
        ins_done  = 1'b0;
        ins_pos   = '0;
        cur_new   = r_new;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_new;
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (r_state)
            ST_IDLE: begin
                cur_new = in_ent;
                if (go_ins) begin
                    if (r_occ == '0) begin
                        ins_done = 1'b1;
                    end else begin
                        // start the walk at the tail
                        mem_re    = 1'b1;
                        mem_raddr = atmrq_pkg::ring_idx(r_head,
                                        atmrq_pkg::IDX_W'(r_occ - 1'b1));
                    end
                end
            end
            ST_WALK: begin
                if (walk_shift) begin
                    // move the later entry up one slot
                    mem_we    = 1'b1;
                    mem_waddr = atmrq_pkg::ring_idx(r_head, r_pos + 1'b1);
                    mem_wdata = rd_ent;
                    if (r_pos != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = atmrq_pkg::ring_idx(r_head, r_pos - 1'b1);
                    end
                end else begin
                    ins_done = 1'b1;
                    ins_pos  = r_pos + 1'b1;
                end
            end
            ST_PLACE: begin
                ins_done = 1'b1;
            end
            ST_HEAD: begin
                mem_re    = 1'b1;
                mem_raddr = r_head;
            end
            ST_TAKE, ST_EMIT: begin
            end
            default: begin
            end
        endcase
        if (ins_done) begin
            mem_we    = 1'b1;
            mem_waddr = atmrq_pkg::ring_idx(r_head, ins_pos);
            mem_wdata = cur_new;
        end
        n_vcnt = r_vcnt + atmrq_pkg::CNT_W'(ins_done && cur_new.vid);
        n_acnt = r_acnt + atmrq_pkg::CNT_W'(ins_done && !cur_new.vid);
        rel    = atmrq_pkg::release_ok(n_vcnt, n_acnt, r_thr);
    end

    atmrq_ram #(
        .WIDTH (atmrq_pkg::ENT_W),
        .DEPTH (atmrq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mix       <= 1'b0;
            r_thr       <= atmrq_pkg::THR_RESET;
            r_pub       <= 1'b0;
            r_mono      <= 1'b1;
            r_last      <= '0;
            r_occ       <= '0;
            r_vcnt      <= '0;
            r_acnt      <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    atmrq_pkg::CFG_MIX_ENABLE:     r_mix <= i_cfg_data[0];
                    atmrq_pkg::CFG_PURE_THRESHOLD: r_thr <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // the emit state reloads the output register on its own
            if (r_out_valid && i_out_ready && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            if (ins_done) begin
                r_vcnt <= n_vcnt;
                r_acnt <= n_acnt;
                r_occ  <= r_occ + 1'b1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        unique case (i_mode)
                            atmrq_pkg::MODE_START: begin
                                if (!r_pub) begin
                                    r_occ  <= '0;
                                    r_vcnt <= '0;
                                    r_acnt <= '0;
                                    r_head <= '0;
                                    r_mono <= 1'b1;
                                    r_pub  <= 1'b1;
                                end
                            end
                            atmrq_pkg::MODE_STOP: begin
                                if (r_pub) begin
                                    r_last <= '0;
                                    r_pub  <= 1'b0;
                                end
                            end
                            atmrq_pkg::MODE_MEDIA: begin
                                if (r_pub) begin
                                    if (!r_mix && (r_last != '0) &&
                                        (i_timestamp < r_last)) begin
                                        r_mono <= 1'b0;
                                    end
                                    r_last <= i_timestamp;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (media_ok && !r_mix) begin
                            r_pend  <= in_ent;
                            r_state <= ST_EMIT;
                        end
                        if (go_ins) begin
                            r_new <= in_ent;
                            if (r_occ == '0) begin
                                r_state <= rel ? ST_HEAD : ST_IDLE;
                            end else begin
                                r_pos   <= atmrq_pkg::IDX_W'(r_occ - 1'b1);
                                r_state <= ST_WALK;
                            end
                        end
                    end
                end
                ST_WALK: begin
                    if (ins_done) begin
                        r_state <= rel ? ST_HEAD : ST_IDLE;
                    end else if (r_pos == '0) begin
                        r_state <= ST_PLACE;
                    end else begin
                        r_pos <= r_pos - 1'b1;
                    end
                end
                ST_PLACE: begin
                    r_state <= rel ? ST_HEAD : ST_IDLE;
                end
                ST_HEAD: begin
                    r_state <= ST_TAKE;
                end
                ST_TAKE: begin
                    // drop the head entry and advance the ring
                    r_pend <= rd_ent;
                    if (rd_ent.vid) begin
                        r_vcnt <= r_vcnt - 1'b1;
                    end else begin
                        r_acnt <= r_acnt - 1'b1;
                    end
                    r_occ   <= r_occ - 1'b1;
                    r_head  <= atmrq_pkg::ring_idx(r_head, atmrq_pkg::IDX_W'(1));
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_tag   <= r_pend.tag;
                        r_out_ts    <= r_pend.ts;
                        r_out_vid   <= r_pend.vid;
                        r_out_mono  <= r_mono;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`include "av_timestamp_mix_reorder_queue_core_macros.svh"

    `ATMRQ_ASSERT_IMPL(a_occ_sum, i_clk, i_rst_n, 1'b1,
        (r_occ == (r_vcnt + r_acnt)), "occupancy does not match kind counts")
    `ATMRQ_ASSERT_IMPL(a_idle_room, i_clk, i_rst_n, (r_state == ST_IDLE),
        (r_occ < atmrq_pkg::DEPTH_CW), "queue full while idle")
    `ATMRQ_ASSERT_IMPL(a_walk_pos, i_clk, i_rst_n, (r_state == ST_WALK),
        (atmrq_pkg::CNT_W'(r_pos) < r_occ), "walk position outside the queue")
    `ATMRQ_ASSERT_IMPL(a_take_nonempty, i_clk, i_rst_n, (r_state == ST_TAKE),
        (r_occ != '0), "release from an empty queue")
    `ATMRQ_ASSERT_NEXT(a_head_then_take, i_clk, i_rst_n, (r_state == ST_HEAD),
        (r_state == ST_TAKE), "head read not followed by take")

endmodule
`default_nettype wire
